// File: rtl/sms_pkg.sv
`timescale 1ns / 1ps

package sms_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd2;

    localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] t_pat;

    typedef struct packed {
        logic [FIELD_W-1:0] match_start;
        logic [FIELD_W-1:0] match_end;
        logic [FIELD_W-1:0] match_count;
    } t_result;

endpackage

// File: rtl/sms_if.sv
`timescale 1ns / 1ps

interface sms_text_if;
    import sms_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              text_start;

    modport source (output valid, output text_byte, output text_start, input ready);
    modport sink   (input valid, input text_byte, input text_start, output ready);
endinterface

interface sms_match_if;
    import sms_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] match_start;
    logic [FIELD_W-1:0] match_end;
    logic [FIELD_W-1:0] match_count;

    modport source (output valid, output match_start, output match_end,
                    output match_count, input ready);
    modport sink   (input valid, input match_start, input match_end,
                    input match_count, output ready);
endinterface

interface sms_cfg_if;
    import sms_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sms_cell.sv
`timescale 1ns / 1ps

module sms_cell #(
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [sms_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_ok,
    input  logic [sms_pkg::LEN_W-1:0]  i_len,
    input  sms_pkg::t_pat              i_pat,
    output logic [sms_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_ok
);
    import sms_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  w_sel;
    logic              w_used;

    // history byte IDX lines up with pattern byte len-2-IDX
    assign w_used = (LEN_W'(IDX + 2) <= i_len);
    assign w_sel  = i_len - LEN_W'(IDX + 2);
    assign o_ok   = i_ok && (!w_used || (r_byte == i_pat[w_sel[3:0]]));
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: rtl/sms_out.sv
`timescale 1ns / 1ps

module sms_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sms_pkg::t_result i_res,
    output logic             o_full,
    sms_match_if.source      o_match
);
    import sms_pkg::*;

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    w_pop;

    assign w_pop  = !r_out_valid || o_match.ready;
    assign o_full = r_skid_valid;

    assign o_match.valid       = r_out_valid;
    assign o_match.match_start = r_out.match_start;
    assign o_match.match_end   = r_out.match_end;
    assign o_match.match_count = r_out.match_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
                if (i_push) begin
                    r_skid <= i_res;
                end
            end else begin
                r_out_valid <= i_push;
                if (i_push) begin
                    r_out <= i_res;
                end
            end
        end else if (i_push) begin
            r_skid       <= i_res;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

// File: rtl/substring_match_stream.sv
`timescale 1ns / 1ps

// Streaming substring search.
// i_text   : text bytes, one transaction per byte; text_start marks the first
//            byte of a new text and clears position and match count.
// i_cfg    : register writes (0 length, 1 pattern bytes 0-7, 2 bytes 8-15),
//            always ready; write only while no transactions are in flight.
// o_match  : one transaction per completed occurrence, overlapping ones
//            included, with 1-based start/end positions and running count.
// Throughput: one text byte per cycle. The window compare is a chain of
// MAX_PATTERN-1 history cells, each comparing its stored byte with its
// pattern byte, ANDed along the chain.
// Each result is registered in the output stage before it reaches o_match.
// Stall: a two-entry output stage (register plus skid) lets input flow while
// one result waits; i_text.ready drops only when both entries are full.
// Reset: registers return to zero length (no matches), position and count
// clear, output stage empties. History bytes are not cleared; they are
// ignored until enough bytes of the current text have arrived.

module substring_match_stream #(
    parameter int MAX_PATTERN        = 16,
    parameter int TEXT_POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sms_text_if.sink    i_text,
    sms_cfg_if.sink     i_cfg,
    sms_match_if.source o_match
);
    import sms_pkg::*;

    localparam int POS_W = TEXT_POSITION_BITS;
    localparam int OUT_W = (POS_W > FIELD_W) ? POS_W : FIELD_W;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic [LEN_W-1:0]     r_len;
    logic [CFG_DAT_W-1:0] r_pat_lo;
    logic [CFG_DAT_W-1:0] r_pat_hi;
    logic [POS_W-1:0]     r_pos;
    logic [FIELD_W-1:0]   r_count;

    t_pat                 w_pat;
    logic                 w_accept;
    logic                 w_skid_full;
    logic [LEN_W-1:0]     w_head_sel;
    logic                 w_len_ok;
    logic [POS_W-1:0]     w_pos_base;
    logic [POS_W-1:0]     n_pos;
    logic [FIELD_W-1:0]   w_count_base;
    logic [FIELD_W-1:0]   n_count;
    logic                 w_hit;
    logic [OUT_W-1:0]     w_end_ext;
    logic [OUT_W-1:0]     w_start_ext;
    t_result              w_res;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] w_chain_byte;
    logic [MAX_PATTERN-1:0]             w_chain_ok;

    assign i_cfg.ready  = 1'b1;
    assign i_text.ready = !w_skid_full;
    assign w_accept     = i_text.valid && !w_skid_full;
    assign w_pat        = {r_pat_hi, r_pat_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LENGTH:   r_len    <= i_cfg.data[LEN_W-1:0];
                CFG_PAT_LOW:  r_pat_lo <= i_cfg.data;
                CFG_PAT_HIGH: r_pat_hi <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // current byte against pattern byte len-1, then the history cells
    assign w_len_ok   = (r_len != '0) && (r_len <= LEN_W'(MAX_PATTERN));
    assign w_head_sel = r_len - LEN_W'(1);
    assign w_chain_byte[0] = i_text.text_byte;
    assign w_chain_ok[0]   = w_len_ok && (i_text.text_byte == w_pat[w_head_sel[3:0]]);

    for (genvar g = 0; g < MAX_PATTERN - 1; g++) begin : g_cell
        sms_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_shift(w_accept),
            .i_byte (w_chain_byte[g]),
            .i_ok   (w_chain_ok[g]),
            .i_len  (r_len),
            .i_pat  (w_pat),
            .o_byte (w_chain_byte[g+1]),
            .o_ok   (w_chain_ok[g+1])
        );
    end

    assign w_pos_base   = i_text.text_start ? '0 : r_pos;
    assign n_pos        = (w_pos_base == POS_MAX) ? w_pos_base : w_pos_base + POS_W'(1);
    assign w_hit        = w_chain_ok[MAX_PATTERN-1] && (n_pos >= POS_W'(r_len));
    assign w_count_base = i_text.text_start ? '0 : r_count;
    assign n_count      = (w_hit && (w_count_base != COUNT_MAX)) ?
                          w_count_base + FIELD_W'(1) : w_count_base;

    assign w_end_ext   = OUT_W'(n_pos);
    assign w_start_ext = w_end_ext - OUT_W'(r_len) + OUT_W'(1);

    assign w_res.match_start = w_start_ext[FIELD_W-1:0];
    assign w_res.match_end   = w_end_ext[FIELD_W-1:0];
    assign w_res.match_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    sms_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_accept && w_hit),
        .i_res  (w_res),
        .o_full (w_skid_full),
        .o_match(o_match)
    );

endmodule

// File: rtl/sms_checker.sv
`timescale 1ns / 1ps

module sms_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [sms_pkg::FIELD_W-1:0] i_match_start,
    input logic [sms_pkg::FIELD_W-1:0] i_match_end,
    input logic [sms_pkg::FIELD_W-1:0] i_match_count
);
    import sms_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("match transaction dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_match_start) && $stable(i_match_end) && $stable(i_match_count)))
        else $error("match payload changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output not empty after reset");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_match_count != '0))
        else $error("match reported with zero count");

endmodule

bind substring_match_stream sms_checker u_sms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_match.valid),
    .i_out_ready  (o_match.ready),
    .i_match_start(o_match.match_start),
    .i_match_end  (o_match.match_end),
    .i_match_count(o_match.match_count)
);
